### design/dnsqp_pkg.sv
// ----------------------------------------------------------------------------
// dnsqp_pkg
// Shared types and constants for the DNS question name parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dnsqp_pkg;

    localparam int MAX_PAYLOAD_DEF = 65535;

    // Header byte positions of interest
    localparam int POS_FLAGS_HI = 2;
    localparam int POS_QDCNT_HI = 4;
    localparam int POS_QDCNT_LO = 5;
    localparam int POS_HDR_LAST = 11;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] FLAG_QR    = 8'h80;
    localparam logic [7:0] LEN_EXT    = 8'hC0;
    localparam logic [15:0] CLASS_IN  = 16'd1;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_SHORT_HDR   = 4'd1,
        ST_RESPONSE    = 4'd2,
        ST_NO_QUESTION = 4'd3,
        ST_COMPRESSED  = 4'd4,
        ST_LABEL_OVR   = 4'd5,
        ST_TAIL_TRUNC  = 4'd6,
        ST_EMPTY_NAME  = 4'd7,
        ST_BAD_QTYPE   = 4'd8
    } status_t;

endpackage

`default_nettype wire

### design/dns_question_name_parser_top.sv
// A result appears on m_tvalid in the cycle after the byte that causes it.
// Throughput: one payload byte per cycle; the output register lets a new byte
// in whenever it is empty or being drained in the same cycle.
// Reset (rst_n low, async) clears the parser state and the output valid; the
// parser state also returns to its reset values after every last byte.
// ----------------------------------------------------------------------------
// dns_question_name_parser_top
// Walks the DNS header and first question name, streams the name characters
// with dots between labels, and reports a status on the last payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_question_name_parser_top #(
    parameter int MAX_PAYLOAD = dnsqp_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] name_char, [11:8] status,
                                        // [27:12] qtype, [31:28] zero
    output logic             m_tuser,   // char_valid
    output logic             m_tlast    // done_res
);
    import dnsqp_pkg::*;

    localparam int CountW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CountW-1:0] CountMax = CountW'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN,
        PH_LABEL,
        PH_TAIL,
        PH_DONE,
        PH_FAIL
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [CountW-1:0] byte_count_reg, byte_count_next;
    logic [5:0]        label_left_reg, label_left_next;
    logic              name_started_reg, name_started_next;
    status_t           failure_reg, failure_next;
    logic [7:0]        count_high_reg, count_high_next;
    logic [2:0]        tail_count_reg, tail_count_next;
    logic [15:0]       type_word_reg, type_word_next;
    logic [15:0]       class_word_reg, class_word_next;

    logic              out_valid_reg;
    logic              out_char_valid_reg;
    logic [7:0]        out_char_reg;
    logic              out_done_reg;
    status_t           out_status_reg;
    logic [15:0]       out_qtype_reg;

    logic              accept;
    logic              char_valid;
    logic [7:0]        char_byte;
    status_t           status;
    logic [15:0]       qtype;
    logic              res_valid;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        label_left_next   = label_left_reg;
        name_started_next = name_started_reg;
        failure_next      = failure_reg;
        count_high_next   = count_high_reg;
        tail_count_next   = tail_count_reg;
        type_word_next    = type_word_reg;
        class_word_next   = class_word_reg;
        char_valid        = 1'b0;
        char_byte         = 8'd0;
        status            = ST_OK;
        qtype             = 16'd0;

        if (byte_count_reg != CountMax)
        begin
            byte_count_next = byte_count_reg + CountW'(1);
        end

        case (phase_reg)
            PH_HEADER:
            begin
                if (byte_count_reg == CountW'(POS_FLAGS_HI) && (s_tdata & FLAG_QR) != 8'd0)
                begin
                    failure_next = ST_RESPONSE;
                end
                if (byte_count_reg == CountW'(POS_QDCNT_HI))
                begin
                    count_high_next = s_tdata;
                end
                if (byte_count_reg == CountW'(POS_QDCNT_LO) && count_high_reg == 8'd0
                    && s_tdata == 8'd0 && failure_reg == ST_OK)
                begin
                    failure_next = ST_NO_QUESTION;
                end
                if (byte_count_reg == CountW'(POS_HDR_LAST))
                begin
                    phase_next = (failure_next != ST_OK) ? PH_FAIL : PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (s_tdata == 8'd0)
                begin
                    phase_next      = PH_TAIL;
                    tail_count_next = 3'd0;
                end
                else if ((s_tdata & LEN_EXT) != 8'd0)
                begin
                    failure_next = ST_COMPRESSED;
                    phase_next   = PH_FAIL;
                end
                else
                begin
                    // dot goes out on the length byte of every label after the first
                    char_valid        = name_started_reg;
                    char_byte         = name_started_reg ? CHAR_DOT : 8'd0;
                    name_started_next = 1'b1;
                    label_left_next   = s_tdata[5:0];
                    phase_next        = PH_LABEL;
                end
            end
            PH_LABEL:
            begin
                char_valid      = 1'b1;
                char_byte       = s_tdata;
                label_left_next = label_left_reg - 6'd1;
                if (label_left_next == 6'd0)
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_TAIL:
            begin
                if (tail_count_reg < 3'd2)
                begin
                    type_word_next = {type_word_reg[7:0], s_tdata};
                end
                else
                begin
                    class_word_next = {class_word_reg[7:0], s_tdata};
                end
                tail_count_next = tail_count_reg + 3'd1;
                if (tail_count_reg >= 3'd3)
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        if (s_tlast)
        begin
            case (phase_next)
                PH_HEADER: status = ST_SHORT_HDR;
                PH_FAIL:   status = failure_next;
                PH_LEN:    status = ST_TAIL_TRUNC;
                PH_LABEL:  status = ST_LABEL_OVR;
                PH_TAIL:   status = ST_TAIL_TRUNC;
                default:
                begin
                    if (!name_started_next)
                    begin
                        status = ST_EMPTY_NAME;
                    end
                    else if (class_word_next != CLASS_IN || type_word_next == 16'd0)
                    begin
                        status = ST_BAD_QTYPE;
                    end
                    else
                    begin
                        status = ST_OK;
                        qtype  = type_word_next;
                    end
                end
            endcase
            char_valid        = 1'b0;
            char_byte         = 8'd0;
            phase_next        = PH_HEADER;
            byte_count_next   = '0;
            label_left_next   = 6'd0;
            name_started_next = 1'b0;
            failure_next      = ST_OK;
            count_high_next   = 8'd0;
            tail_count_next   = 3'd0;
            type_word_next    = 16'd0;
            class_word_next   = 16'd0;
        end

        res_valid = s_tlast || char_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            byte_count_reg   <= '0;
            label_left_reg   <= 6'd0;
            name_started_reg <= 1'b0;
            failure_reg      <= ST_OK;
            count_high_reg   <= 8'd0;
            tail_count_reg   <= 3'd0;
            type_word_reg    <= 16'd0;
            class_word_reg   <= 16'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg        <= phase_next;
                byte_count_reg   <= byte_count_next;
                label_left_reg   <= label_left_next;
                name_started_reg <= name_started_next;
                failure_reg      <= failure_next;
                count_high_reg   <= count_high_next;
                tail_count_reg   <= tail_count_next;
                type_word_reg    <= type_word_next;
                class_word_reg   <= class_word_next;
            end
            if (accept && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_char_valid_reg <= char_valid;
            out_char_reg       <= char_byte;
            out_done_reg       <= s_tlast;
            out_status_reg     <= status;
            out_qtype_reg      <= qtype;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_qtype_reg, out_status_reg, out_char_reg};
    assign m_tuser  = out_char_valid_reg;
    assign m_tlast  = out_done_reg;

endmodule

`default_nettype wire

### design/dnsqp_checker.sv
// ----------------------------------------------------------------------------
// dnsqp_checker
// Port-level checks for the DNS question name parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsqp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);
    import dnsqp_pkg::*;

    // a character item is never the end-of-payload item
    a_char_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tlast)
        else $error("character item flagged as done");

    // character items carry no status or type
    a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser && m_tdata[27:8] == 20'd0)
        else $error("character item with status or type set");

    // done item: no character, type only on success
    a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[7:0] == 8'd0
            && (m_tdata[11:8] == ST_OK || m_tdata[27:12] == 16'd0))
        else $error("done item fields inconsistent");

    // full output register stalls the input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while result stalled");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind dns_question_name_parser_top dnsqp_checker u_dnsqp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### test/tb_dns_question_name_parser_top.sv
// ----------------------------------------------------------------------------
// tb_dns_question_name_parser_top
// Drives DNS payloads byte by byte into the question name parser, predicts the
// name characters and the final status of each payload, and checks every
// output item against the prediction under random input gaps and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dns_question_name_parser_top;

    timeunit 1ns;
    timeprecision 1ps;

    import dnsqp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int BYTE_TARGET  = 1550;
    localparam int QUIET_AFTER  = 1300;

    typedef enum logic [2:0] {
        P_HEADER, P_LEN, P_LABEL, P_TAIL, P_DONE, P_FAIL
    } parse_phase_t;

    typedef struct packed {
        logic        char_valid;
        logic [7:0]  name_char;
        logic        done;
        status_t     status;
        logic [15:0] qtype;
    } parse_result_t;

    class name_parse_scoreboard;
        parse_phase_t  phase;
        logic [15:0]   byte_count;
        logic [5:0]    label_left;
        logic          name_started;
        status_t       failure;
        logic [7:0]    count_high;
        logic [2:0]    tail_count;
        logic [15:0]   type_word;
        logic [15:0]   class_word;
        parse_result_t expected_q[$];
        int            errors;
        int            chars_seen;
        int            ok_seen;
        int            rejected_seen;

        function new();
            errors = 0;
            chars_seen = 0;
            ok_seen = 0;
            rejected_seen = 0;
            clear();
        endfunction

        function void clear();
            phase        = P_HEADER;
            byte_count   = '0;
            label_left   = '0;
            name_started = 1'b0;
            failure      = ST_OK;
            count_high   = '0;
            tail_count   = '0;
            type_word    = '0;
            class_word   = '0;
        endfunction

        // Advance the parser by one accepted byte, queue what it should emit.
        function void note_input(logic [7:0] b, logic last);
            logic [15:0]   pos;
            logic          cv;
            logic [7:0]    ch;
            parse_result_t r;
            pos = byte_count;
            cv  = 1'b0;
            ch  = '0;
            if (byte_count < 16'(MAX_PAYLOAD_DEF))
                byte_count = byte_count + 16'd1;

            case (phase)
                P_HEADER:
                begin
                    if (pos == 16'(POS_FLAGS_HI) && (b & FLAG_QR) != 0)
                        failure = ST_RESPONSE;
                    if (pos == 16'(POS_QDCNT_HI))
                        count_high = b;
                    if (pos == 16'(POS_QDCNT_LO) && count_high == 0 && b == 0
                        && failure == ST_OK)
                        failure = ST_NO_QUESTION;
                    if (pos == 16'(POS_HDR_LAST))
                        phase = (failure != ST_OK) ? P_FAIL : P_LEN;
                end
                P_LEN:
                begin
                    if (b == 0)
                    begin
                        phase = P_TAIL;
                        tail_count = '0;
                    end
                    else if ((b & LEN_EXT) != 0)
                    begin
                        failure = ST_COMPRESSED;
                        phase = P_FAIL;
                    end
                    else
                    begin
                        if (name_started)
                        begin
                            cv = 1'b1;
                            ch = CHAR_DOT;
                        end
                        name_started = 1'b1;
                        label_left = b[5:0];
                        phase = P_LABEL;
                    end
                end
                P_LABEL:
                begin
                    cv = 1'b1;
                    ch = b;
                    label_left = label_left - 6'd1;
                    if (label_left == 0)
                        phase = P_LEN;
                end
                P_TAIL:
                begin
                    if (tail_count < 3'd2)
                        type_word = {type_word[7:0], b};
                    else
                        class_word = {class_word[7:0], b};
                    tail_count = tail_count + 3'd1;
                    if (tail_count >= 3'd4)
                        phase = P_DONE;
                end
                default: ;
            endcase

            if (last)
            begin
                r = '0;
                r.done = 1'b1;
                case (phase)
                    P_HEADER: r.status = ST_SHORT_HDR;
                    P_FAIL:   r.status = failure;
                    P_LEN:    r.status = ST_TAIL_TRUNC;
                    P_LABEL:  r.status = ST_LABEL_OVR;
                    P_TAIL:   r.status = ST_TAIL_TRUNC;
                    default:
                    begin
                        if (!name_started)
                            r.status = ST_EMPTY_NAME;
                        else if (class_word != CLASS_IN || type_word == 0)
                            r.status = ST_BAD_QTYPE;
                        else
                        begin
                            r.status = ST_OK;
                            r.qtype = type_word;
                        end
                    end
                endcase
                expected_q.push_back(r);
                clear();
            end
            else if (cv)
            begin
                r = '0;
                r.char_valid = 1'b1;
                r.name_char = ch;
                r.status = ST_OK;
                expected_q.push_back(r);
            end
        endfunction

        function void check_result(logic [31:0] data, logic user, logic lst);
            parse_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected item: tdata=%h tuser=%b tlast=%b", data, user, lst);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (user !== e.char_valid)
            begin
                $error("char_valid: expected %b, actual %b", e.char_valid, user);
                errors++;
            end
            if (data[7:0] !== e.name_char)
            begin
                $error("name_char: expected %h, actual %h", e.name_char, data[7:0]);
                errors++;
            end
            if (lst !== e.done)
            begin
                $error("done_res: expected %b, actual %b", e.done, lst);
                errors++;
            end
            if (data[11:8] !== 4'(e.status))
            begin
                $error("status: expected %0d, actual %0d", e.status, data[11:8]);
                errors++;
            end
            if (data[27:12] !== e.qtype)
            begin
                $error("qtype: expected %h, actual %h", e.qtype, data[27:12]);
                errors++;
            end
            if (data[31:28] !== 4'd0)
            begin
                $error("tdata pad: expected 0, actual %h", data[31:28]);
                errors++;
            end
            if (e.char_valid)
                chars_seen++;
            if (e.done && e.status == ST_OK)
                ok_seen++;
            else if (e.done)
                rejected_seen++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] data_byte
    logic        s_tlast = 1'b0;   // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [7:0] name_char, [11:8] status,
                                   // [27:12] qtype, [31:28] zero
    logic        m_tuser;          // char_valid
    logic        m_tlast;          // done_res

    name_parse_scoreboard sb = new();

    logic [7:0] pkt[$];
    int         tx_gap_pct = 0;
    int         rx_stall_pct = 0;
    bit         hold_req = 1'b0;
    int         bytes_sent = 0;
    int         payloads_sent = 0;
    int         cycle_count = 0;

    dns_question_name_parser_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // Output side: random stall bursts, plus one long hold on request.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic add_header(input logic resp, input logic [15:0] qd);
        pkt.push_back(8'($urandom));
        pkt.push_back(8'($urandom));
        pkt.push_back({resp, 7'($urandom)});
        pkt.push_back(8'($urandom));
        pkt.push_back(qd[15:8]);
        pkt.push_back(qd[7:0]);
        repeat (6) pkt.push_back(8'($urandom));
    endtask

    task automatic add_label(input int len);
        pkt.push_back(8'(len));
        repeat (len) pkt.push_back(8'($urandom));
    endtask

    task automatic add_tail(input logic [15:0] qtype, input logic [15:0] qclass);
        pkt.push_back(qtype[15:8]);
        pkt.push_back(qtype[7:0]);
        pkt.push_back(qclass[15:8]);
        pkt.push_back(qclass[7:0]);
    endtask

    task automatic cut_to(input int n);
        while (pkt.size() > n)
            void'(pkt.pop_back());
    endtask

    // Valid stays high across back-to-back bytes; it only drops for a gap.
    task automatic send_payload();
        for (int i = 0; i < pkt.size(); i++)
        begin
            if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= pkt[i];
            s_tlast  <= (i == pkt.size() - 1);
            do
                @(posedge clk);
            while (!s_tready);
            sb.note_input(pkt[i], i == pkt.size() - 1);
            bytes_sent++;
        end
        pkt.delete();
        payloads_sent++;
    endtask

    task automatic random_payload();
        int          flavor;
        int          nlab;
        int          maxlen;
        logic [15:0] qd;
        logic [15:0] qtype;
        logic [15:0] qclass;
        flavor = $urandom_range(0, 99);
        if (flavor >= 96)
        begin
            // plain noise
            repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
            return;
        end
        do
            qd = 16'($urandom);
        while (qd == 0);
        if (flavor >= 89 && flavor <= 92)
            qd = '0;
        add_header(flavor >= 84 && flavor <= 88, qd);
        nlab = (flavor >= 93 && flavor <= 95) ? 0 : $urandom_range(1, 4);
        repeat (nlab)
        begin
            maxlen = ($urandom_range(0, 19) == 0) ? 63 : 10;
            add_label($urandom_range(1, maxlen));
        end
        if (flavor >= 78 && flavor <= 83)
        begin
            // pointer or extended label type where a length belongs
            pkt.push_back(8'($urandom_range(64, 255)));
            repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom));
            return;
        end
        pkt.push_back(8'h00);
        qtype  = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom);
        qclass = ($urandom_range(0, 9) == 0) ? 16'($urandom) : CLASS_IN;
        add_tail(qtype, qclass);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
        if (flavor >= 70 && flavor <= 77)
            cut_to($urandom_range(1, pkt.size()));
    endtask

    task automatic directed_payloads();
        // extreme label sizes and content, widest type word
        add_header(1'b0, 16'h0001);
        pkt.push_back(8'd2);
        pkt.push_back(8'h00);
        pkt.push_back(8'hFF);
        add_label(63);
        pkt.push_back(8'h00);
        add_tail(16'hFFFF, CLASS_IN);
        send_payload();
        // question count with only the high byte set, trailing bytes
        add_header(1'b0, 16'h0100);
        add_label(1);
        pkt.push_back(8'h00);
        add_tail(16'h0001, CLASS_IN);
        pkt.push_back(8'hA5);
        pkt.push_back(8'h5A);
        send_payload();
        // short header, one byte
        pkt.push_back(8'hFF);
        send_payload();
        // short header carrying response flag and zero count
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(8'h80);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        send_payload();
        // response with no questions: response wins
        add_header(1'b1, 16'h0000);
        add_label(3);
        send_payload();
        // query with no questions
        add_header(1'b0, 16'h0000);
        add_label(2);
        pkt.push_back(8'h00);
        add_tail(16'h0001, CLASS_IN);
        send_payload();
        // compression pointer, then extended label type
        add_header(1'b0, 16'h0001);
        add_label(3);
        pkt.push_back(8'hC0);
        pkt.push_back(8'h0C);
        send_payload();
        add_header(1'b0, 16'h0001);
        pkt.push_back(8'h40);
        send_payload();
        // ends inside a label, then right after a length byte
        add_header(1'b0, 16'h0001);
        add_label(5);
        cut_to(pkt.size() - 2);
        send_payload();
        add_header(1'b0, 16'h0001);
        pkt.push_back(8'd4);
        send_payload();
        // header only, ends right after a label, ends mid tail
        add_header(1'b0, 16'h0001);
        send_payload();
        add_header(1'b0, 16'h0001);
        add_label(3);
        send_payload();
        add_header(1'b0, 16'h0001);
        pkt.push_back(8'h00);
        add_tail(16'h0001, CLASS_IN);
        cut_to(pkt.size() - 2);
        send_payload();
        // empty name with full tail
        add_header(1'b0, 16'h0001);
        pkt.push_back(8'h00);
        add_tail(16'h001C, CLASS_IN);
        send_payload();
        // bad class, then zero type
        add_header(1'b0, 16'h0001);
        add_label(2);
        pkt.push_back(8'h00);
        add_tail(16'h0001, 16'h0002);
        send_payload();
        add_header(1'b0, 16'h0001);
        add_label(2);
        pkt.push_back(8'h00);
        add_tail(16'h0000, CLASS_IN);
        send_payload();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_payloads();

        // long output hold while a long name keeps the input busy
        hold_req = 1'b1;
        add_header(1'b0, 16'h0001);
        add_label(63);
        add_label(63);
        pkt.push_back(8'h00);
        add_tail(16'h0041, CLASS_IN);
        send_payload();

        while (bytes_sent < BYTE_TARGET)
        begin
            if (bytes_sent > QUIET_AFTER)
            begin
                tx_gap_pct = 0;
                rx_stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: tx_gap_pct = 0;
                    1: tx_gap_pct = 10;
                    default: tx_gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: rx_stall_pct = 0;
                    1: rx_stall_pct = 10;
                    default: rx_stall_pct = 40;
                endcase
            end
            random_payload();
            send_payload();
        end
        s_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.expected_q.size() != 0)
        begin
            $error("%0d expected items never arrived", sb.expected_q.size());
            sb.errors++;
        end

        $display("Sent %0d payloads (%0d bytes): header, label and tail faults, noise",
                 payloads_sent, bytes_sent);
        $display("Checked %0d name chars, %0d accepted and %0d rejected payloads",
                 sb.chars_seen, sb.ok_seen, sb.rejected_seen);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
